[hw/rtl/mmeu_pkg.sv]
// package for the multi-motor encoder unwrap block: sizes, status codes and
// the structs passed between the tracker, the scaler and the top level
// no dependencies
`default_nettype none

package mmeu_pkg;

   localparam int MOTOR_SLOTS = 8;
   localparam int SLOT_W      = $clog2(MOTOR_SLOTS);
   localparam int GEAR_REGS   = 8;
   localparam int GEAR_IDX_W  = $clog2(GEAR_REGS);

   localparam int ID_W      = 11;
   localparam int ENC_W     = 13;
   localparam int SPEED_W   = 16;
   localparam int CURRENT_W = 16;
   localparam int CNT_W     = 6;
   localparam int TURN_W    = 24;
   localparam int ROTOR_W   = 37;
   localparam int AXIS_W    = 45;
   localparam int AXSPD_W   = 24;
   localparam int GEAR_W    = 16;
   localparam int STATUS_W  = 2;

   // rotor * gear is split at this bit into two narrower products
   localparam int ROTOR_LO_W = 19;
   localparam int ROTOR_HI_W = ROTOR_W - ROTOR_LO_W;
   localparam int PP_LO_W    = ROTOR_LO_W + GEAR_W;
   localparam int PP_HI_W    = ROTOR_HI_W + GEAR_W + 1;
   localparam int PROD_W     = ROTOR_W + GEAR_W;
   localparam int SPROD_W    = SPEED_W + GEAR_W + 1;
   localparam int FRAC_SHIFT = 8;

   localparam logic [ID_W-1:0]   ID_BASE     = 11'h201;
   localparam logic [CNT_W-1:0]  CAL_FRAMES  = 6'd50;
   localparam logic [GEAR_W-1:0] GEAR_RESET  = 16'd3412;
   localparam int                HALF_TURN   = (1 << ENC_W) / 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_CAL   = 2'd0,
      ST_TRACK = 2'd1,
      ST_BAD   = 2'd2
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]  frame_id;
      logic [ENC_W-1:0] encoder_angle;
   } track_in_type;

   typedef struct packed {
      status_type                 status;
      logic [SLOT_W-1:0]          slot;
      logic signed [ROTOR_W-1:0]  rotor;
   } track_out_type;

   typedef struct packed {
      status_type                  status;
      logic [SLOT_W-1:0]           slot;
      logic signed [ROTOR_W-1:0]   rotor;
      logic [GEAR_W-1:0]           gear;
      logic signed [SPEED_W-1:0]   speed;
      logic signed [CURRENT_W-1:0] current;
   } scale_in_type;

endpackage

`default_nettype wire

[hw/rtl/multi_motor_encoder_unwrap.sv]
// top level of the multi-motor encoder unwrap block
// uses mmeu_pkg, mmeu_track and mmeu_scale
//
// req_ stream: one motor feedback frame per item. tuser carries the 11-bit
// frame identifier (motors at 0x201 upward), tdata the angle, speed, current.
// rsp_ stream: one result item per frame, status in tuser, positions, speed
// and current in tdata. An identifier outside the motor range gives status 2
// and zero data without touching any motor state.
// csr_ port: csr_we with csr_index 0..7 writes the Q8.8 reciprocal gear
// ratio of that motor; write only while no item is in flight.
// Throughput is one item per cycle while rsp_tready is high. An accepted
// item passes the input register, the state update, the partial products
// and the combining add into the result register that drives rsp_tvalid.
// The per-motor state is read and written in the same cycle, so frames for the
// same motor can follow each other back to back.
// When rsp_tready is low, the result register holds and the earlier stages
// keep filling until all are full; req_tready drops only then.
// Reset (synchronous) clears all motor state, empties the pipeline and sets
// every gear register to 3412.
`default_nettype none

module multi_motor_encoder_unwrap import mmeu_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [47:0]           req_tdata,  // encoder_angle, speed_rpm,
                                                  // motor_current, zero fill
   input  wire logic [15:0]           req_tuser,  // frame_id, zero fill
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [127:0]               rsp_tdata,  // motor_index, rotor_position,
                                                  // axis_position, axis_speed,
                                                  // current_out, zero fill
   output logic [7:0]                 rsp_tuser,  // status, zero fill
   input  wire logic                  csr_we,
   input  wire logic [GEAR_IDX_W-1:0] csr_index,
   input  wire logic [GEAR_W-1:0]     csr_wdata
);

   logic [GEAR_W-1:0]           gear_ff [GEAR_REGS];

   logic                        a_valid_ff;
   track_in_type                a_frame_ff;
   logic signed [SPEED_W-1:0]   a_speed_ff;
   logic signed [CURRENT_W-1:0] a_current_ff;

   logic                        b_valid_ff;
   scale_in_type                b_item_ff;

   logic                        load_a;
   logic                        load_b;
   logic                        scale_ready;
   track_out_type               track_res;
   scale_in_type                b_item_in;

   assign load_b     = !b_valid_ff || scale_ready;
   assign load_a     = !a_valid_ff || load_b;
   assign req_tready = load_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < GEAR_REGS; k++) begin
            gear_ff[k] <= GEAR_RESET;
         end
      end else if (csr_we) begin
         gear_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (load_a) begin
            a_valid_ff <= req_tvalid;
         end
         if (load_b) begin
            b_valid_ff <= a_valid_ff;
         end
      end
      if (load_a && req_tvalid) begin
         a_frame_ff.frame_id      <= req_tuser[ID_W-1:0];
         a_frame_ff.encoder_angle <= req_tdata[ENC_W-1:0];
         a_speed_ff               <= $signed(req_tdata[ENC_W+SPEED_W-1:ENC_W]);
         a_current_ff             <= $signed(req_tdata[ENC_W+SPEED_W+CURRENT_W-1:
                                                       ENC_W+SPEED_W]);
      end
      if (load_b && a_valid_ff) begin
         b_item_ff <= b_item_in;
      end
   end

   mmeu_track u_track (
      .clock  (clock),
      .reset  (reset),
      .update (load_b && a_valid_ff),
      .frame  (a_frame_ff),
      .result (track_res)
   );

   always_comb begin
      b_item_in.status = track_res.status;
      b_item_in.slot   = track_res.slot;
      b_item_in.rotor  = track_res.rotor;
      if (track_res.status == ST_BAD) begin
         // zero gear and inputs force every data field to zero
         b_item_in.gear    = '0;
         b_item_in.speed   = '0;
         b_item_in.current = '0;
      end else begin
         b_item_in.gear    = gear_ff[GEAR_IDX_W'(track_res.slot)];
         b_item_in.speed   = a_speed_ff;
         b_item_in.current = a_current_ff;
      end
   end

   mmeu_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (b_valid_ff),
      .in_ready   (scale_ready),
      .in_item    (b_item_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

[hw/rtl/mmeu_track.sv]
// per-motor unwrap state: calibration count, offset, previous angle, turns
// computes the rotor position of one frame; depends on mmeu_pkg
`default_nettype none

module mmeu_track import mmeu_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          update,
   input  wire track_in_type  frame,
   output track_out_type      result
);

   logic [CNT_W-1:0]  frame_count_ff [MOTOR_SLOTS];
   logic [ENC_W-1:0]  prev_angle_ff  [MOTOR_SLOTS];
   logic [ENC_W-1:0]  offset_ff      [MOTOR_SLOTS];
   logic [TURN_W-1:0] turn_ff        [MOTOR_SLOTS];

   logic [ID_W-1:0]          id_diff;
   logic                     in_range;
   logic [SLOT_W-1:0]        slot;
   logic                     calibrating;
   logic signed [ENC_W:0]    delta;
   logic [CNT_W-1:0]         count_in;
   logic [ENC_W-1:0]         prev_in;
   logic [ENC_W-1:0]         offset_in;
   logic [TURN_W-1:0]        turn_in;
   logic signed [ENC_W:0]    frac;
   logic [ROTOR_W-1:0]       rotor;

   always_comb begin
      id_diff     = frame.frame_id - ID_BASE;
      in_range    = (frame.frame_id >= ID_BASE) && (id_diff < ID_W'(MOTOR_SLOTS));
      slot        = id_diff[SLOT_W-1:0];
      calibrating = frame_count_ff[slot] < CAL_FRAMES;
      delta       = $signed({1'b0, frame.encoder_angle}) - $signed({1'b0, prev_angle_ff[slot]});

      count_in  = frame_count_ff[slot];
      offset_in = offset_ff[slot];
      turn_in   = turn_ff[slot];
      prev_in   = frame.encoder_angle;
      if (calibrating) begin
         offset_in = frame.encoder_angle;
         count_in  = frame_count_ff[slot] + CNT_W'(1);
      end else if (delta > (ENC_W+1)'(HALF_TURN)) begin
         // forward jump past half a turn: wrapped backward
         turn_in = turn_ff[slot] - TURN_W'(1);
      end else if (delta < -(ENC_W+1)'(HALF_TURN)) begin
         turn_in = turn_ff[slot] + TURN_W'(1);
      end

      frac  = $signed({1'b0, prev_in}) - $signed({1'b0, offset_in});
      rotor = {turn_in, {ENC_W{1'b0}}} + ROTOR_W'(frac);

      if (!in_range) begin
         result.status = ST_BAD;
         result.slot   = '0;
         result.rotor  = '0;
      end else begin
         result.status = calibrating ? ST_CAL : ST_TRACK;
         result.slot   = slot;
         result.rotor  = $signed(rotor);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MOTOR_SLOTS; k++) begin
            frame_count_ff[k] <= '0;
            prev_angle_ff[k]  <= '0;
            offset_ff[k]      <= '0;
            turn_ff[k]        <= '0;
         end
      end else if (update && in_range) begin
         frame_count_ff[slot] <= count_in;
         prev_angle_ff[slot]  <= prev_in;
         offset_ff[slot]      <= offset_in;
         turn_ff[slot]        <= turn_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/mmeu_scale.sv]
// gear scaling pipeline: partial products, then combine into the result register
// drives the rsp_ stream; depends on mmeu_pkg
`default_nettype none

module mmeu_scale import mmeu_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire scale_in_type  in_item,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [127:0]       rsp_tdata,  // motor_index, rotor_position, axis_position,
                                          // axis_speed, current_out, zero fill
   output logic [7:0]         rsp_tuser   // status, zero fill
);

   logic                        c_valid_ff;
   status_type                  c_status_ff;
   logic [SLOT_W-1:0]           c_slot_ff;
   logic signed [ROTOR_W-1:0]   c_rotor_ff;
   logic signed [CURRENT_W-1:0] c_current_ff;
   logic [PP_LO_W-1:0]          c_pp_lo_ff;
   logic signed [PP_HI_W-1:0]   c_pp_hi_ff;
   logic signed [SPROD_W-1:0]   c_sprod_ff;

   logic                        d_valid_ff;
   status_type                  d_status_ff;
   logic [SLOT_W-1:0]           d_slot_ff;
   logic [ROTOR_W-1:0]          d_rotor_ff;
   logic [AXIS_W-1:0]           d_axis_ff;
   logic [AXSPD_W-1:0]          d_axspd_ff;
   logic [CURRENT_W-1:0]        d_current_ff;

   logic                        load_c;
   logic                        load_d;
   logic [PROD_W-1:0]           prod_in;

   assign load_d   = !d_valid_ff || rsp_tready;
   assign load_c   = !c_valid_ff || load_d;
   assign in_ready = load_c;

   // rotor = hi * 2^19 + lo, so rotor * gear = (hi * gear) << 19 + lo * gear
   assign prod_in = {c_pp_hi_ff[PROD_W-ROTOR_LO_W-1:0], {ROTOR_LO_W{1'b0}}}
                  + PROD_W'(c_pp_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (load_c) begin
            c_valid_ff <= in_valid;
         end
         if (load_d) begin
            d_valid_ff <= c_valid_ff;
         end
      end
      if (load_c && in_valid) begin
         c_status_ff  <= in_item.status;
         c_slot_ff    <= in_item.slot;
         c_rotor_ff   <= in_item.rotor;
         c_current_ff <= in_item.current;
         c_pp_lo_ff   <= in_item.rotor[ROTOR_LO_W-1:0] * in_item.gear;
         c_pp_hi_ff   <= $signed(in_item.rotor[ROTOR_W-1:ROTOR_LO_W])
                       * $signed({1'b0, in_item.gear});
         c_sprod_ff   <= in_item.speed * $signed({1'b0, in_item.gear});
      end
      if (load_d && c_valid_ff) begin
         d_status_ff  <= c_status_ff;
         d_slot_ff    <= c_slot_ff;
         d_rotor_ff   <= c_rotor_ff;
         d_current_ff <= c_current_ff;
         // arithmetic shift right by the fraction bits floors toward minus infinity
         d_axis_ff    <= prod_in[PROD_W-1:FRAC_SHIFT];
         d_axspd_ff   <= c_sprod_ff[AXSPD_W+FRAC_SHIFT-1:FRAC_SHIFT];
      end
   end

   assign rsp_tvalid = d_valid_ff;
   assign rsp_tdata  = {3'd0, d_current_ff, d_axspd_ff, d_axis_ff, d_rotor_ff, d_slot_ff};
   assign rsp_tuser  = {6'd0, d_status_ff};

endmodule

`default_nettype wire

[hw/rtl/mmeu_checker.sv]
// port-level checks for multi_motor_encoder_unwrap, attached with bind
// depends on mmeu_pkg
`default_nettype none

module mmeu_checker import mmeu_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [47:0]           req_tdata,
   input wire logic [15:0]           req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [127:0]          rsp_tdata,
   input wire logic [7:0]            rsp_tuser,
   input wire logic                  csr_we,
   input wire logic [GEAR_IDX_W-1:0] csr_index,
   input wire logic [GEAR_W-1:0]     csr_wdata
);

   // pipeline is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // with an empty result register no stage can be blocking the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // an out-of-range identifier gives all-zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[STATUS_W-1:0] == ST_BAD |-> rsp_tdata == '0)
      else $error("error status with nonzero data");

   // while calibrating, offset equals angle and no turns have been counted
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[STATUS_W-1:0] == ST_CAL
         |-> rsp_tdata[SLOT_W+ROTOR_W+AXIS_W-1:SLOT_W] == '0)
      else $error("nonzero position during calibration");

endmodule

bind multi_motor_encoder_unwrap mmeu_checker u_mmeu_checker (.*);

`default_nettype wire
